/* hw/rtl/mctl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctl_pkg
// Types, character codes and step functions shared by the text lexer files.
// ----------------------------------------------------------------------------
package mctl_pkg;

   localparam int TEXT_CHARS_DEF = 8;
   localparam int TEXT_WIDTH     = 64;
   localparam int LINE_WIDTH     = 20;
   localparam int VALUE_WIDTH    = 32;
   localparam int SLOT_COUNT     = 3;

   localparam logic [7:0] CHAR_LBRACE     = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE     = 8'h7D;
   localparam logic [7:0] CHAR_COLON      = 8'h3A;
   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [7:0] CHAR_TAB        = 8'h09;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_PLUS       = 8'h2B;
   localparam logic [7:0] CHAR_MINUS      = 8'h2D;
   localparam logic [7:0] CHAR_POINT      = 8'h2E;
   localparam logic [7:0] CHAR_ZERO       = 8'h30;

   localparam logic [LINE_WIDTH-1:0]  LINE_MAX    = 20'hFFFFF;
   localparam logic [VALUE_WIDTH-1:0] MAG_LIMIT   = 32'h8000_0000;
   localparam logic [VALUE_WIDTH-1:0] POS_LIMIT   = 32'h7FFF_FFFF;
   localparam logic [3:0]             FRAC_MAX    = 4'd15;
   localparam logic [7:0]             LENGTH_MAX  = 8'd255;

   typedef logic [TEXT_WIDTH-1:0] text_type;

   typedef enum logic [2:0] {
      KIND_IDENT   = 3'd0,
      KIND_INT     = 3'd1,
      KIND_DEC     = 3'd2,
      KIND_SPECIAL = 3'd3,
      KIND_END     = 3'd4,
      KIND_ERROR   = 3'd5
   } token_kind_type;

   typedef enum logic [2:0] {
      CL_LETTER  = 3'd0,
      CL_DIGIT   = 3'd1,
      CL_SPECIAL = 3'd2,
      CL_BLANK   = 3'd3,
      CL_UNDER   = 3'd4,
      CL_SIGN    = 3'd5,
      CL_POINT   = 3'd6,
      CL_ILLEGAL = 3'd7
   } char_class_type;

   // FAIL is only a step outcome; it is never held in the state register
   typedef enum logic [6:0] {
      ST_BEGIN = 7'b000_0001,
      ST_UNDER = 7'b000_0010,
      ST_IDENT = 7'b000_0100,
      ST_SIGN  = 7'b000_1000,
      ST_INT   = 7'b001_0000,
      ST_DEC   = 7'b010_0000,
      ST_FAIL  = 7'b100_0000
   } lex_state_type;

   typedef struct packed {
      token_kind_type            kind;
      logic [LINE_WIDTH-1:0]     line;
      logic [VALUE_WIDTH-1:0]    value;
      logic [3:0]                frac;
      text_type                  text;
      logic [7:0]                length;
   } rsp_item_type;

   typedef struct packed {
      logic [SLOT_COUNT-1:0]     mask;   // token, special sign, end
      rsp_item_type [SLOT_COUNT-1:0] slot;
   } rsp_bundle_type;

   function automatic char_class_type classify(input logic [7:0] b);
      char_class_type cls;
      if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) begin
         cls = CL_LETTER;
      end else if (b >= 8'h30 && b <= 8'h39) begin
         cls = CL_DIGIT;
      end else if (b == CHAR_LBRACE || b == CHAR_RBRACE || b == CHAR_COLON) begin
         cls = CL_SPECIAL;
      end else if (b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_NEWLINE) begin
         cls = CL_BLANK;
      end else if (b == CHAR_UNDERSCORE) begin
         cls = CL_UNDER;
      end else if (b == CHAR_PLUS || b == CHAR_MINUS) begin
         cls = CL_SIGN;
      end else if (b == CHAR_POINT) begin
         cls = CL_POINT;
      end else begin
         cls = CL_ILLEGAL;
      end
      return cls;
   endfunction

   function automatic lex_state_type next_state(input lex_state_type st,
                                                input char_class_type cls);
      lex_state_type ns;
      ns = ST_FAIL;
      case (st)
         ST_BEGIN: begin
            case (cls)
               CL_LETTER:  ns = ST_IDENT;
               CL_DIGIT:   ns = ST_INT;
               CL_SPECIAL: ns = ST_BEGIN;
               CL_BLANK:   ns = ST_BEGIN;
               CL_UNDER:   ns = ST_UNDER;
               CL_SIGN:    ns = ST_SIGN;
               default:    ns = ST_FAIL;
            endcase
         end
         ST_UNDER: begin
            case (cls)
               CL_LETTER: ns = ST_IDENT;
               CL_UNDER:  ns = ST_UNDER;
               default:   ns = ST_FAIL;
            endcase
         end
         ST_IDENT: begin
            case (cls)
               CL_LETTER:  ns = ST_IDENT;
               CL_DIGIT:   ns = ST_IDENT;
               CL_UNDER:   ns = ST_IDENT;
               CL_SPECIAL: ns = ST_BEGIN;
               CL_BLANK:   ns = ST_BEGIN;
               default:    ns = ST_FAIL;
            endcase
         end
         ST_SIGN: begin
            case (cls)
               CL_DIGIT: ns = ST_INT;
               default:  ns = ST_FAIL;
            endcase
         end
         ST_INT: begin
            case (cls)
               CL_DIGIT:   ns = ST_INT;
               CL_POINT:   ns = ST_DEC;
               CL_SPECIAL: ns = ST_BEGIN;
               CL_BLANK:   ns = ST_BEGIN;
               default:    ns = ST_FAIL;
            endcase
         end
         ST_DEC: begin
            case (cls)
               CL_DIGIT:   ns = ST_DEC;
               CL_SPECIAL: ns = ST_BEGIN;
               CL_BLANK:   ns = ST_BEGIN;
               default:    ns = ST_FAIL;
            endcase
         end
         default: ns = ST_FAIL;
      endcase
      return ns;
   endfunction

   // mag*10 + d, held at 2^31 once it reaches it
   function automatic logic [VALUE_WIDTH-1:0] add_digit(input logic [VALUE_WIDTH-1:0] mag,
                                                        input logic [3:0] d);
      logic [VALUE_WIDTH+3:0] sum;
      sum = {mag, 3'b000} + {2'b00, mag, 1'b0} + {{VALUE_WIDTH{1'b0}}, d};
      return (sum >= {4'b0000, MAG_LIMIT}) ? MAG_LIMIT : sum[VALUE_WIDTH-1:0];
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] signed_value(input logic [VALUE_WIDTH-1:0] mag,
                                                           input logic neg);
      logic [VALUE_WIDTH-1:0] v;
      if (neg) begin
         v = (mag >= MAG_LIMIT) ? MAG_LIMIT : (~mag + 32'd1);
      end else begin
         v = (mag >= MAG_LIMIT) ? POS_LIMIT : mag;
      end
      return v;
   endfunction

   function automatic rsp_item_type make_item(input token_kind_type kind,
                                              input logic [LINE_WIDTH-1:0] line);
      rsp_item_type it;
      it        = '0;
      it.kind   = kind;
      it.line   = line;
      return it;
   endfunction

endpackage

/* hw/rtl/mctl_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctl_req_if
// Byte channel into the lexer: valid/ready with one text byte per transfer.
// ----------------------------------------------------------------------------
interface mctl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       final_byte;

   modport source (output valid, output text_byte, output final_byte, input ready);
   modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

/* hw/rtl/mctl_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctl_rsp_if
// Token channel out of the lexer: valid/ready with one token per transfer.
// ----------------------------------------------------------------------------
interface mctl_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         token_kind;
   logic [19:0]        line_number;
   logic signed [31:0] number_value;
   logic [3:0]         fraction_digits;
   logic [63:0]        token_text;
   logic [7:0]         text_length;
   logic               last_result;

   modport source (output valid, output token_kind, output line_number,
                   output number_value, output fraction_digits, output token_text,
                   output text_length, output last_result, input ready);
   modport sink   (input valid, input token_kind, input line_number,
                   input number_value, input fraction_digits, input token_text,
                   input text_length, input last_result, output ready);
endinterface

/* hw/rtl/motion_capture_text_lexer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_capture_text_lexer
// Table-driven lexer for motion-capture text, one byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//  req_chan carries one text byte per transfer; final_byte marks the end of a
//  text. rsp_chan carries tokens: identifier, integer, decimal, special sign,
//  end and error, each with its line number; last_result flags the last token
//  a byte gives. A byte gives zero to three tokens.
//  Data path: a byte passes the input register, then the lexer step, and its
//  tokens are loaded into the token register, from which they transfer.
//  Throughput: one byte per cycle while each byte gives at most one token and
//  rsp_chan.ready is high; a byte with n tokens holds the token register until
//  all n have transferred, as the port moves one token per cycle while ready is high.
//  Reset (synchronous): lexer back to the start state, line 1, no error,
//  both registers empty. A final byte also returns the lexer to that state.
//  Stalls: with rsp_chan.ready low the token register holds and the input
//  register still takes one more byte; after that req_chan.ready drops.
//  After a byte that fails the table step an error token is given and later
//  bytes are dropped until the final byte, which gives only the end token.
// ----------------------------------------------------------------------------
module motion_capture_text_lexer #(
   parameter int TextChars = mctl_pkg::TEXT_CHARS_DEF   // identifier chars kept, 1..8
) (
   input  logic       clock,
   input  logic       reset,
   mctl_req_if.sink   req_chan,
   mctl_rsp_if.source rsp_chan
);

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_final_ff;

   logic                     can_load;   // token register free after this edge
   logic                     advance;    // held byte steps the lexer this cycle
   mctl_pkg::rsp_bundle_type bundle;

   assign advance        = in_valid_ff && can_load;
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   // payload only moves on a transfer
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff  <= req_chan.text_byte;
         in_final_ff <= req_chan.final_byte;
      end
   end

   // classify, table step, accumulate; tokens for the held byte
   mctl_lexer #(
      .TextChars (TextChars)
   ) u_lexer (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .text_byte  (in_byte_ff),
      .final_byte (in_final_ff),
      .bundle     (bundle)
   );

   // token register, emptied one transfer at a time
   mctl_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .bundle   (bundle),
      .can_load (can_load),
      .rsp_chan (rsp_chan)
   );

`ifndef NO_ASSERTIONS
   // tokens of one byte leave back to back
   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.last_result) |=> rsp_chan.valid)
      else $error("token burst broken before its last token");

   // the end token always closes a byte
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.token_kind == mctl_pkg::KIND_END) |-> rsp_chan.last_result)
      else $error("end token not flagged last");

   // an error token can only be followed, within its byte, by the end token
   a_error_then_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.last_result &&
       rsp_chan.token_kind == mctl_pkg::KIND_ERROR)
      |=> (rsp_chan.valid && rsp_chan.token_kind == mctl_pkg::KIND_END))
      else $error("error token followed by something other than end");
`endif

endmodule

/* hw/rtl/mctl_lexer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctl_lexer
// Lexer state and one table step per byte; builds up to three tokens.
// ----------------------------------------------------------------------------
module mctl_lexer #(
   parameter int TextChars = mctl_pkg::TEXT_CHARS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,
   input  logic [7:0]              text_byte,
   input  logic                    final_byte,
   output mctl_pkg::rsp_bundle_type bundle
);

   localparam int TextBits = 8 * TextChars;

   mctl_pkg::lex_state_type  state_ff, state_in;
   logic                     error_ff, error_in;
   logic [19:0]              line_ff, line_in;
   logic [31:0]              accum_ff, accum_in;
   logic                     neg_ff, neg_in;
   logic [3:0]               frac_ff, frac_in;
   logic [TextBits-1:0]      text_ff, text_in;
   logic [7:0]               length_ff, length_in;

   mctl_pkg::char_class_type cls;
   mctl_pkg::lex_state_type  ns;
   logic                     normal, fail;
   logic [19:0]              line_step;
   logic [3:0]               digit;
   mctl_pkg::rsp_item_type   tok, spec, fin_item;
   logic                     tok_valid, spec_valid;

   function automatic logic is_token(input mctl_pkg::lex_state_type st);
      return st == mctl_pkg::ST_IDENT || st == mctl_pkg::ST_INT || st == mctl_pkg::ST_DEC;
   endfunction

   function automatic mctl_pkg::rsp_item_type flush(input mctl_pkg::lex_state_type st,
                                                    input logic [31:0] acc,
                                                    input logic neg,
                                                    input logic [3:0] fr,
                                                    input logic [TextBits-1:0] txt,
                                                    input logic [7:0] len,
                                                    input logic [19:0] line);
      mctl_pkg::rsp_item_type it;
      it = mctl_pkg::make_item(mctl_pkg::KIND_IDENT, line);
      case (st)
         mctl_pkg::ST_IDENT: begin
            it.text   = mctl_pkg::text_type'(txt);
            it.length = len;
         end
         mctl_pkg::ST_INT: begin
            it.kind  = mctl_pkg::KIND_INT;
            it.value = mctl_pkg::signed_value(acc, neg);
         end
         mctl_pkg::ST_DEC: begin
            it.kind  = mctl_pkg::KIND_DEC;
            it.value = mctl_pkg::signed_value(acc, neg);
            it.frac  = fr;
         end
         default: it.kind = mctl_pkg::KIND_ERROR;
      endcase
      return it;
   endfunction

   always_comb begin
      cls    = mctl_pkg::classify(text_byte);
      ns     = mctl_pkg::next_state(state_ff, cls);
      normal = !error_ff && (ns != mctl_pkg::ST_FAIL);
      fail   = !error_ff && (ns == mctl_pkg::ST_FAIL);
      digit  = 4'(text_byte - mctl_pkg::CHAR_ZERO);

      line_step = line_ff;
      if (normal && text_byte == mctl_pkg::CHAR_NEWLINE && line_ff != mctl_pkg::LINE_MAX) begin
         line_step = line_ff + 20'd1;
      end

      // token accumulators after this byte
      accum_in  = accum_ff;
      neg_in    = neg_ff;
      frac_in   = frac_ff;
      text_in   = text_ff;
      length_in = length_ff;
      if (ns == mctl_pkg::ST_BEGIN) begin
         accum_in  = '0;
         neg_in    = 1'b0;
         frac_in   = '0;
         text_in   = '0;
         length_in = '0;
      end else if (ns != mctl_pkg::ST_FAIL) begin
         if (ns == mctl_pkg::ST_SIGN) begin
            neg_in = (text_byte == mctl_pkg::CHAR_MINUS);
         end
         if (cls == mctl_pkg::CL_DIGIT) begin
            if (ns == mctl_pkg::ST_INT) begin
               accum_in = mctl_pkg::add_digit(accum_ff, digit);
            end else if (ns == mctl_pkg::ST_DEC && frac_ff < mctl_pkg::FRAC_MAX) begin
               accum_in = mctl_pkg::add_digit(accum_ff, digit);
               frac_in  = frac_ff + 4'd1;
            end
         end
         for (int i = 0; i < TextChars; i++) begin
            if (length_ff == 8'(i)) begin
               text_in[8*i +: 8] = text_byte;
            end
         end
         if (length_ff != mctl_pkg::LENGTH_MAX) begin
            length_in = length_ff + 8'd1;
         end
      end

      // token at the end of the text: pending token, or error on a dangling prefix
      if (ns == mctl_pkg::ST_UNDER || ns == mctl_pkg::ST_SIGN) begin
         fin_item = mctl_pkg::make_item(mctl_pkg::KIND_ERROR, line_step);
      end else begin
         fin_item = flush(ns, accum_in, neg_in, frac_in, text_in, length_in, line_step);
      end

      tok       = mctl_pkg::make_item(mctl_pkg::KIND_ERROR, line_ff);
      tok_valid = 1'b0;
      if (fail) begin
         tok_valid = 1'b1;
      end else if (normal && ns == mctl_pkg::ST_BEGIN) begin
         tok       = flush(state_ff, accum_ff, neg_ff, frac_ff, text_ff, length_ff, line_ff);
         tok_valid = is_token(state_ff);
      end else if (normal && final_byte) begin
         tok       = fin_item;
         tok_valid = (ns != mctl_pkg::ST_BEGIN);
      end

      spec       = mctl_pkg::make_item(mctl_pkg::KIND_SPECIAL, line_ff);
      spec.text  = mctl_pkg::text_type'(text_byte);
      spec_valid = normal && (ns == mctl_pkg::ST_BEGIN) && (cls == mctl_pkg::CL_SPECIAL);

      bundle.mask    = {final_byte, spec_valid, tok_valid};
      bundle.slot[0] = tok;
      bundle.slot[1] = spec;
      bundle.slot[2] = mctl_pkg::make_item(mctl_pkg::KIND_END, line_step);

      state_in = state_ff;
      error_in = error_ff;
      line_in  = line_ff;
      if (final_byte) begin
         state_in = mctl_pkg::ST_BEGIN;
         error_in = 1'b0;
         line_in  = 20'd1;
      end else if (fail) begin
         error_in = 1'b1;
      end else if (normal) begin
         state_in = ns;
         line_in  = line_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mctl_pkg::ST_BEGIN;
         error_ff  <= 1'b0;
         line_ff   <= 20'd1;
         accum_ff  <= '0;
         neg_ff    <= 1'b0;
         frac_ff   <= '0;
         text_ff   <= '0;
         length_ff <= '0;
      end else if (step_en) begin
         state_ff <= state_in;
         error_ff <= error_in;
         line_ff  <= line_in;
         if (final_byte) begin
            accum_ff  <= '0;
            neg_ff    <= 1'b0;
            frac_ff   <= '0;
            text_ff   <= '0;
            length_ff <= '0;
         end else if (normal) begin
            accum_ff  <= accum_in;
            neg_ff    <= neg_in;
            frac_ff   <= frac_in;
            text_ff   <= text_in;
            length_ff <= length_in;
         end
      end
   end

endmodule

/* hw/rtl/mctl_rsp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctl_rsp_queue
// Holds the tokens of one byte and hands them out one transfer at a time.
// ----------------------------------------------------------------------------
module mctl_rsp_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  mctl_pkg::rsp_bundle_type bundle,
   output logic                     can_load,
   mctl_rsp_if.source               rsp_chan
);

   logic [mctl_pkg::SLOT_COUNT-1:0]                         mask_ff, mask_in;
   mctl_pkg::rsp_item_type [mctl_pkg::SLOT_COUNT-1:0]       slot_ff;
   mctl_pkg::rsp_item_type                                  cur;
   logic                                                    single;
   logic                                                    take;

   always_comb begin
      if (mask_ff[0]) begin
         cur = slot_ff[0];
      end else if (mask_ff[1]) begin
         cur = slot_ff[1];
      end else begin
         cur = slot_ff[2];
      end
      single   = (mask_ff & (mask_ff - 3'd1)) == '0;
      take     = rsp_chan.valid && rsp_chan.ready;
      can_load = (mask_ff == '0) || (single && rsp_chan.ready);

      mask_in = mask_ff;
      if (load) begin
         mask_in = bundle.mask;
      end else if (take) begin
         mask_in = mask_ff & (mask_ff - 3'd1);   // drop the lowest pending slot
      end
   end

   assign rsp_chan.valid           = (mask_ff != '0);
   assign rsp_chan.token_kind      = cur.kind;
   assign rsp_chan.line_number     = cur.line;
   assign rsp_chan.number_value    = cur.value;
   assign rsp_chan.fraction_digits = cur.frac;
   assign rsp_chan.token_text      = cur.text;
   assign rsp_chan.text_length     = cur.length;
   assign rsp_chan.last_result     = single;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= bundle.slot;
      end
   end

endmodule
